### hw/rtl/qhs_pkg.sv
// qhs_pkg: shared constants, controller states and command/status types
// for the quicksort sorter; no dependencies
package qhs_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int IJ_W         = IDX_W + 2;
    localparam int STACK_DEPTH  = 64;
    localparam int SP_W         = $clog2(STACK_DEPTH) + 1;
    localparam int DATA_W       = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_INIT,
        S_POP,
        S_POP_WAIT,
        S_PIVOT,
        S_SCAN_I,
        S_SCAN_J,
        S_CHECK,
        S_SWAP_A,
        S_SWAP_B,
        S_TEST,
        S_PUSH_R,
        S_PUSH_L,
        S_EMIT_LD,
        S_EMIT_HOLD
    } t_state;

    typedef enum logic [2:0] {
        RD_MID,
        RD_I,
        RD_I_NXT,
        RD_J,
        RD_J_PRV,
        RD_K,
        RD_K_NXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_FULL,
        PUSH_RIGHT,
        PUSH_LEFT
    } t_push_sel;

    typedef struct packed {
        logic      load_en;
        t_rd_sel   rd_sel;
        t_push_sel push_sel;
        logic      pop;
        logic      range_load;
        logic      pivot_load;
        logic      i_inc;
        logic      j_dec;
        logic      vi_load;
        logic      vj_load;
        logic      swap_a;
        logic      swap_b;
        logic      k_clear;
        logic      k_inc;
        logic      out_load;
        logic      set_clear;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic cnt_lt2;
        logic sp_zero;
        logic i_scan;
        logic j_scan;
        logic i_le_j;
        logic i_lt_hi;
        logic lo_lt_j;
        logic k_last;
        logic out_taken;
    } t_sts;

endpackage

### hw/rtl/qhs_if.sv
// qhs_in_if / qhs_out_if: valid-ready channels for input and sorted items
// depends on qhs_pkg for the data width
interface qhs_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [qhs_pkg::DATA_W-1:0] value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface qhs_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [qhs_pkg::DATA_W-1:0] sorted_value;
    logic                          last_out;
    logic                          overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

### hw/rtl/qhs_datapath.sv
// qhs_datapath: element store, range stack, partition indices, pivot and
// output register; driven by qhs_ctrl commands, depends on qhs_pkg and qhs_if
module qhs_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qhs_pkg::t_cmd   i_cmd,
    output qhs_pkg::t_sts   o_sts,
    qhs_in_if.sink          i_in,
    qhs_out_if.source       o_out
);

    logic [qhs_pkg::DATA_W-1:0] r_store [0:qhs_pkg::MAX_ELEMENTS-1];
    logic [qhs_pkg::DATA_W-1:0] r_rdata;
    logic [2*qhs_pkg::IDX_W-1:0] r_stack [0:qhs_pkg::STACK_DEPTH-1];
    logic [2*qhs_pkg::IDX_W-1:0] r_srdata;

    logic [qhs_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_ovf;
    logic [qhs_pkg::SP_W-1:0]   r_sp;
    logic [qhs_pkg::IDX_W-1:0]  r_lo;
    logic [qhs_pkg::IDX_W-1:0]  r_hi;
    logic [qhs_pkg::IJ_W-1:0]   r_i;
    logic [qhs_pkg::IJ_W-1:0]   r_j;
    logic [qhs_pkg::DATA_W-1:0] r_pivot;
    logic [qhs_pkg::DATA_W-1:0] r_vi;
    logic [qhs_pkg::DATA_W-1:0] r_vj;
    logic [qhs_pkg::IDX_W-1:0]  r_k;

    logic                       r_out_valid;
    logic [qhs_pkg::DATA_W-1:0] r_out_value;
    logic                       r_out_last;
    logic                       r_out_ovf;

    logic                       in_fire;
    logic                       has_room;
    logic [qhs_pkg::IDX_W:0]    mid_sum;
    logic [qhs_pkg::IDX_W-1:0]  rd_addr;
    logic                       wr_en;
    logic [qhs_pkg::IDX_W-1:0]  wr_addr;
    logic [qhs_pkg::DATA_W-1:0] wr_data;
    logic [qhs_pkg::SP_W-1:0]   sp_dec;
    logic [2*qhs_pkg::IDX_W-1:0] push_data;
    logic                       push_en;
    logic [qhs_pkg::IJ_W-1:0]   lo_ext;
    logic [qhs_pkg::IJ_W-1:0]   hi_ext;

    assign in_fire  = i_in.valid && i_in.ready;
    assign has_room = r_cnt < qhs_pkg::CNT_W'(qhs_pkg::MAX_ELEMENTS);
    assign mid_sum  = {1'b0, r_srdata[2*qhs_pkg::IDX_W-1:qhs_pkg::IDX_W]}
                    + {1'b0, r_srdata[qhs_pkg::IDX_W-1:0]};
    assign sp_dec   = r_sp - qhs_pkg::SP_W'(1);
    assign lo_ext   = {2'b00, r_lo};
    assign hi_ext   = {2'b00, r_hi};
    assign push_en  = (i_cmd.push_sel != qhs_pkg::PUSH_NONE)
                   && (r_sp < qhs_pkg::SP_W'(qhs_pkg::STACK_DEPTH));

    assign i_in.ready = i_cmd.load_en;

    always_comb begin
        case (i_cmd.rd_sel)
            qhs_pkg::RD_MID:   rd_addr = mid_sum[qhs_pkg::IDX_W:1];
            qhs_pkg::RD_I:     rd_addr = r_i[qhs_pkg::IDX_W-1:0];
            qhs_pkg::RD_I_NXT: rd_addr = r_i[qhs_pkg::IDX_W-1:0] + qhs_pkg::IDX_W'(1);
            qhs_pkg::RD_J:     rd_addr = r_j[qhs_pkg::IDX_W-1:0];
            qhs_pkg::RD_J_PRV: rd_addr = r_j[qhs_pkg::IDX_W-1:0] - qhs_pkg::IDX_W'(1);
            qhs_pkg::RD_K:     rd_addr = r_k;
            qhs_pkg::RD_K_NXT: rd_addr = r_k + qhs_pkg::IDX_W'(1);
            default:           rd_addr = r_k;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt[qhs_pkg::IDX_W-1:0];
        wr_data = i_in.value;
        if (i_cmd.load_en && in_fire && has_room) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_a) begin
            wr_en   = 1'b1;
            wr_addr = r_i[qhs_pkg::IDX_W-1:0];
            wr_data = r_vj;
        end else if (i_cmd.swap_b) begin
            wr_en   = 1'b1;
            wr_addr = r_j[qhs_pkg::IDX_W-1:0];
            wr_data = r_vi;
        end
    end

    always_comb begin
        case (i_cmd.push_sel)
            qhs_pkg::PUSH_FULL:  push_data = {qhs_pkg::IDX_W'(0),
                                              qhs_pkg::IDX_W'(r_cnt - qhs_pkg::CNT_W'(1))};
            qhs_pkg::PUSH_RIGHT: push_data = {r_i[qhs_pkg::IDX_W-1:0], r_hi};
            qhs_pkg::PUSH_LEFT:  push_data = {r_lo, r_j[qhs_pkg::IDX_W-1:0]};
            default:             push_data = {r_lo, r_hi};
        endcase
    end

    // element store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rdata <= r_store[rd_addr];
    end

    // range stack
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_sp[qhs_pkg::SP_W-2:0]] <= push_data;
        end
        r_srdata <= r_stack[sp_dec[qhs_pkg::SP_W-2:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_sp        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_en && in_fire) begin
                if (has_room) begin
                    r_cnt <= r_cnt + qhs_pkg::CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.set_clear) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
            if (push_en) begin
                r_sp <= r_sp + qhs_pkg::SP_W'(1);
            end else if (i_cmd.pop) begin
                r_sp <= sp_dec;
            end
            if (i_cmd.k_clear) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + qhs_pkg::IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.range_load) begin
            r_lo <= r_srdata[2*qhs_pkg::IDX_W-1:qhs_pkg::IDX_W];
            r_hi <= r_srdata[qhs_pkg::IDX_W-1:0];
            r_i  <= {2'b00, r_srdata[2*qhs_pkg::IDX_W-1:qhs_pkg::IDX_W]};
            r_j  <= {2'b00, r_srdata[qhs_pkg::IDX_W-1:0]};
        end else begin
            if (i_cmd.i_inc || i_cmd.swap_b) begin
                r_i <= r_i + qhs_pkg::IJ_W'(1);
            end
            if (i_cmd.j_dec || i_cmd.swap_b) begin
                r_j <= r_j - qhs_pkg::IJ_W'(1);
            end
        end
        if (i_cmd.pivot_load) begin
            r_pivot <= r_rdata;
        end
        if (i_cmd.vi_load) begin
            r_vi <= r_rdata;
        end
        if (i_cmd.vj_load) begin
            r_vj <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_rdata;
            r_out_last  <= o_sts.k_last;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.last_out     = r_out_last;
    assign o_out.overflow     = r_out_ovf;

    always_comb begin
        o_sts.in_fire   = in_fire;
        o_sts.in_last   = i_in.last;
        o_sts.cnt_lt2   = r_cnt < qhs_pkg::CNT_W'(2);
        o_sts.sp_zero   = r_sp == '0;
        o_sts.i_scan    = ($signed(r_rdata) < $signed(r_pivot))
                       && ($signed(r_i) < $signed(hi_ext));
        o_sts.j_scan    = ($signed(r_pivot) < $signed(r_rdata))
                       && ($signed(r_j) > $signed(lo_ext));
        o_sts.i_le_j    = $signed(r_i) <= $signed(r_j);
        o_sts.i_lt_hi   = $signed(r_i) < $signed(hi_ext);
        o_sts.lo_lt_j   = $signed(lo_ext) < $signed(r_j);
        o_sts.k_last    = ({1'b0, r_k} + qhs_pkg::CNT_W'(1)) == r_cnt;
        o_sts.out_taken = o_out.valid && o_out.ready;
    end

endmodule

### hw/rtl/qhs_ctrl.sv
// qhs_ctrl: state machine sequencing load, partition passes and emission
// depends on qhs_pkg
module qhs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qhs_pkg::t_sts i_sts,
    output qhs_pkg::t_cmd o_cmd
);

    qhs_pkg::t_state r_state;
    qhs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qhs_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qhs_pkg::S_LOAD: begin
                if (i_sts.in_fire && i_sts.in_last) n_state = qhs_pkg::S_SORT_INIT;
            end
            qhs_pkg::S_SORT_INIT: begin
                n_state = qhs_pkg::S_POP;
            end
            qhs_pkg::S_POP: begin
                n_state = i_sts.sp_zero ? qhs_pkg::S_EMIT_LD : qhs_pkg::S_POP_WAIT;
            end
            qhs_pkg::S_POP_WAIT: n_state = qhs_pkg::S_PIVOT;
            qhs_pkg::S_PIVOT:    n_state = qhs_pkg::S_SCAN_I;
            qhs_pkg::S_SCAN_I: begin
                if (!i_sts.i_scan) n_state = qhs_pkg::S_SCAN_J;
            end
            qhs_pkg::S_SCAN_J: begin
                if (!i_sts.j_scan) n_state = qhs_pkg::S_CHECK;
            end
            qhs_pkg::S_CHECK: begin
                n_state = i_sts.i_le_j ? qhs_pkg::S_SWAP_A : qhs_pkg::S_PUSH_R;
            end
            qhs_pkg::S_SWAP_A: n_state = qhs_pkg::S_SWAP_B;
            qhs_pkg::S_SWAP_B: n_state = qhs_pkg::S_TEST;
            qhs_pkg::S_TEST: begin
                n_state = i_sts.i_le_j ? qhs_pkg::S_SCAN_I : qhs_pkg::S_PUSH_R;
            end
            qhs_pkg::S_PUSH_R:  n_state = qhs_pkg::S_PUSH_L;
            qhs_pkg::S_PUSH_L:  n_state = qhs_pkg::S_POP;
            qhs_pkg::S_EMIT_LD: n_state = qhs_pkg::S_EMIT_HOLD;
            qhs_pkg::S_EMIT_HOLD: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.k_last ? qhs_pkg::S_LOAD : qhs_pkg::S_EMIT_LD;
                end
            end
            default: n_state = qhs_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = qhs_pkg::RD_I;
        o_cmd.push_sel = qhs_pkg::PUSH_NONE;
        case (r_state)
            qhs_pkg::S_LOAD: begin
                o_cmd.load_en = 1'b1;
            end
            qhs_pkg::S_SORT_INIT: begin
                o_cmd.rd_sel  = qhs_pkg::RD_K;
                o_cmd.k_clear = 1'b1;
                if (!i_sts.cnt_lt2) o_cmd.push_sel = qhs_pkg::PUSH_FULL;
            end
            qhs_pkg::S_POP: begin
                o_cmd.rd_sel = qhs_pkg::RD_K;
                if (i_sts.sp_zero) begin
                    o_cmd.k_clear = 1'b1;
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            qhs_pkg::S_POP_WAIT: begin
                o_cmd.range_load = 1'b1;
                o_cmd.rd_sel     = qhs_pkg::RD_MID;
            end
            qhs_pkg::S_PIVOT: begin
                o_cmd.pivot_load = 1'b1;
                o_cmd.rd_sel     = qhs_pkg::RD_I;
            end
            qhs_pkg::S_SCAN_I: begin
                if (i_sts.i_scan) begin
                    o_cmd.i_inc  = 1'b1;
                    o_cmd.rd_sel = qhs_pkg::RD_I_NXT;
                end else begin
                    o_cmd.vi_load = 1'b1;
                    o_cmd.rd_sel  = qhs_pkg::RD_J;
                end
            end
            qhs_pkg::S_SCAN_J: begin
                if (i_sts.j_scan) begin
                    o_cmd.j_dec  = 1'b1;
                    o_cmd.rd_sel = qhs_pkg::RD_J_PRV;
                end else begin
                    o_cmd.vj_load = 1'b1;
                end
            end
            qhs_pkg::S_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
            end
            qhs_pkg::S_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
            end
            qhs_pkg::S_TEST: begin
                o_cmd.rd_sel = qhs_pkg::RD_I;
            end
            qhs_pkg::S_PUSH_R: begin
                if (i_sts.i_lt_hi) o_cmd.push_sel = qhs_pkg::PUSH_RIGHT;
            end
            qhs_pkg::S_PUSH_L: begin
                if (i_sts.lo_lt_j) o_cmd.push_sel = qhs_pkg::PUSH_LEFT;
            end
            qhs_pkg::S_EMIT_LD: begin
                o_cmd.out_load = 1'b1;
            end
            qhs_pkg::S_EMIT_HOLD: begin
                if (i_sts.out_taken) begin
                    if (i_sts.k_last) begin
                        o_cmd.set_clear = 1'b1;
                    end else begin
                        o_cmd.k_inc  = 1'b1;
                        o_cmd.rd_sel = qhs_pkg::RD_K_NXT;
                    end
                end
            end
            default: begin
                o_cmd.rd_sel = qhs_pkg::RD_I;
            end
        endcase
    end

endmodule

### hw/rtl/quicksort_hoare_sorter_top.sv
// quicksort_hoare_sorter_top: top level joining qhs_ctrl and qhs_datapath
// depends on qhs_pkg, qhs_if, qhs_ctrl and qhs_datapath
//
// usage: signed 32-bit items arrive on i_in, one per accepted handshake, and
// are stored until an item with last set is accepted. up to 64 items are held;
// further items of the same set are dropped and overflow is set on every
// sorted item of that set. after the last item the store is sorted in place
// by quicksort (middle pivot, explicit range stack) and the items leave on
// o_out in ascending order, last_out set on the final one.
// after loading, the store is sorted range by range: a range is popped from
// the stack, its middle item is read as pivot, i and j scan inward and each
// pair found is swapped with one store write per element until they cross,
// then each part of two or more items is pushed while the stack has room.
// in emission each item is read from the store into the output register,
// and the next item is read only after the previous one has been taken.
// i_in.ready is low from the last item until the final sorted item is taken.
// a stalled receiver simply holds the output register and the sorter waits.
// synchronous reset clears the item count, overflow flag, stack pointer and output
// valid; the store needs no clearing as every entry is written before use.
module quicksort_hoare_sorter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qhs_in_if.sink    i_in,
    qhs_out_if.source o_out
);

    qhs_pkg::t_cmd cmd;
    qhs_pkg::t_sts sts;

    qhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    qhs_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

### dv/qhs_sort_checker.sv
`timescale 1ns / 1ps
// qhs_sort_checker: watches both channels of the quicksort sorter, predicts each
// sorted data set and compares every output item field by field
// depends on qhs_pkg and the qhs_in_if / qhs_out_if interfaces
module qhs_sort_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    qhs_in_if    i_in,
    qhs_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        logic signed [qhs_pkg::DATA_W-1:0] value;
        logic                              last;
        logic                              ovf;
    } t_sorted_item;

    logic signed [qhs_pkg::DATA_W-1:0] held [qhs_pkg::MAX_ELEMENTS];
    int                                held_count;
    logic                              dropped;
    t_sorted_item                      sorted_due [$];
    int                                fail_count;

    // middle pivot partition, swap then step both indices, range stack in place of recursion
    function automatic void quicksort_held();
        int                                lo_q [$];
        int                                hi_q [$];
        int                                lo;
        int                                hi;
        int                                i;
        int                                j;
        logic signed [qhs_pkg::DATA_W-1:0] pivot;
        logic signed [qhs_pkg::DATA_W-1:0] tmp;
        if (held_count < 2) return;
        lo_q.push_back(0);
        hi_q.push_back(held_count - 1);
        while (lo_q.size() > 0) begin
            lo = lo_q.pop_back();
            hi = hi_q.pop_back();
            i = lo;
            j = hi;
            pivot = held[(lo + hi) / 2];
            do begin
                while (held[i] < pivot && i < hi) i++;
                while (pivot < held[j] && j > lo) j--;
                if (i <= j) begin
                    tmp = held[i];
                    held[i] = held[j];
                    held[j] = tmp;
                    i++;
                    j--;
                end
            end while (i <= j);
            // right part pushed first so the left part is taken next
            if (i < hi && lo_q.size() < qhs_pkg::STACK_DEPTH) begin
                lo_q.push_back(i);
                hi_q.push_back(hi);
            end
            if (lo < j && lo_q.size() < qhs_pkg::STACK_DEPTH) begin
                lo_q.push_back(lo);
                hi_q.push_back(j);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_sorted_item due;
        t_sorted_item item;
        if (!i_rst_n) begin
            held_count = 0;
            dropped = 1'b0;
            sorted_due.delete();
            fail_count = 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (held_count < qhs_pkg::MAX_ELEMENTS) begin
                    held[held_count] = i_in.value;
                    held_count++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_in.last) begin
                    quicksort_held();
                    for (int k = 0; k < held_count; k++) begin
                        item.value = held[k];
                        item.last = (k == held_count - 1);
                        item.ovf = dropped;
                        sorted_due.push_back(item);
                    end
                    held_count = 0;
                    dropped = 1'b0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (sorted_due.size() == 0) begin
                    $error("unexpected sorted item: sorted_value %0d last_out %0b overflow %0b",
                           i_out.sorted_value, i_out.last_out, i_out.overflow);
                    fail_count++;
                end else begin
                    due = sorted_due.pop_front();
                    if (i_out.sorted_value !== due.value) begin
                        $error("sorted_value: expected %0d, actual %0d",
                               due.value, i_out.sorted_value);
                        fail_count++;
                    end
                    if (i_out.last_out !== due.last) begin
                        $error("last_out: expected %0b, actual %0b", due.last, i_out.last_out);
                        fail_count++;
                    end
                    if (i_out.overflow !== due.ovf) begin
                        $error("overflow: expected %0b, actual %0b", due.ovf, i_out.overflow);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending <= sorted_due.size();
    end

endmodule

### dv/quicksort_hoare_sorter_top_test.sv
`timescale 1ns / 1ps
// quicksort_hoare_sorter_top_test: clock, reset and random item traffic for the
// quicksort sorter, with qhs_sort_checker alongside giving the failure count
// depends on qhs_pkg, qhs_if, quicksort_hoare_sorter_top and qhs_sort_checker
module quicksort_hoare_sorter_top_test;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam logic signed [qhs_pkg::DATA_W-1:0] VALUE_MIN =
        {1'b1, {(qhs_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [qhs_pkg::DATA_W-1:0] VALUE_MAX =
        {1'b0, {(qhs_pkg::DATA_W-1){1'b1}}};

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    bit          idling_on;
    bit          hold_req;
    int          items_sent;
    int unsigned cycle_count;

    qhs_in_if  in_ch ();
    qhs_out_if out_ch ();

    quicksort_hoare_sorter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    qhs_sort_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic signed [qhs_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2, 3: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic signed [qhs_pkg::DATA_W-1:0] v, input logic l);
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_set(input int size);
        int unsigned gap_pct;
        gap_pct = pick_idle_pct();
        for (int k = 0; k < size; k++) begin
            if (idling_on && $urandom_range(1, 100) <= gap_pct) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            send_item(rand_value(), k == size - 1);
        end
    endtask

    // receiver side: random stall bursts, calm stretches and one long hold-off
    initial begin
        int unsigned stall_pct;
        int          stretch;
        stall_pct = 0;
        stretch = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stretch == 0) begin
                stretch = 64;
                stall_pct = pick_idle_pct();
            end
            stretch--;
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idling_on && $urandom_range(1, 100) <= stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        idling_on = 1'b1;
        hold_req = 1'b0;
        items_sent = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single item set, then a pair of extremes
        send_item(VALUE_MIN, 1'b1);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MIN, 1'b1);
        // duplicates, zero crossings and extremes mixed
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(-5, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MIN, 1'b0);
        send_item(5, 1'b1);
        // already ascending, then descending
        for (int k = 0; k < 6; k++) send_item(k - 2, k == 5);
        for (int k = 0; k < 6; k++) send_item(3 - k, k == 5);

        // full store, two small sets, then a set that overflows with the last item dropped
        send_set(qhs_pkg::MAX_ELEMENTS);
        hold_req = 1'b1;
        send_set(8);
        send_set(4);
        send_set(qhs_pkg::MAX_ELEMENTS + 2);
        while (items_sent < 170) send_set($urandom_range(1, 12));
        idling_on = 1'b0;
        while (items_sent < 200) send_set($urandom_range(1, 12));
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/qhs_pkg.sv
hw/rtl/qhs_if.sv
hw/rtl/qhs_datapath.sv
hw/rtl/qhs_ctrl.sv
hw/rtl/quicksort_hoare_sorter_top.sv
dv/qhs_sort_checker.sv
dv/quicksort_hoare_sorter_top_test.sv
